FILE: hw/rtl/rva_pkg.sv
// shared constants and control types for the running variance accumulator
// used by the channel interfaces, controller, datapath and top level
package rva_pkg;

  // fixed field widths of the request channels
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned MEAN_W   = 24;
  localparam int unsigned VAR_W    = 47;

  // default values of the top level parameters
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned COUNT_BITS_DEF  = 32;
  localparam int unsigned FRAC_BITS_DEF   = 8;

  // controller to datapath commands
  typedef struct packed {
    logic take_in;   // capture the input request
    logic sq;        // square the sample magnitude
    logic upd;       // group clear and accumulate
    logic mean_ld;   // start the mean division
    logic mean_st;   // store the mean quotient
    logic var_ld;    // start the mean-of-squares division
    logic load_out;  // load the result register
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic cnt_zero;
    logic out_busy;
  } sts_t;

endpackage

FILE: hw/rtl/rva_in_if.sv
// input request channel: valid/ready handshake with sample payload
// depends on rva_pkg for field widths
interface rva_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [rva_pkg::SAMPLE_W-1:0] sample;
  logic                              sample_missing;
  logic                              group_start;

  modport source (output valid, sample, sample_missing, group_start, input ready);
  modport sink   (input valid, sample, sample_missing, group_start, output ready);
endinterface

FILE: hw/rtl/rva_out_if.sv
// result request channel: valid/ready handshake with statistics payload
// depends on rva_pkg for field widths
interface rva_out_if;
  logic                               valid;
  logic                               ready;
  logic [rva_pkg::COUNT_W-1:0]        sample_count;
  logic signed [rva_pkg::MEAN_W-1:0]  mean_q8;
  logic [rva_pkg::VAR_W-1:0]          variance_q16;
  logic                               no_data;
  logic                               count_saturated;

  modport source (output valid, sample_count, mean_q8, variance_q16, no_data,
                  count_saturated, input ready);
  modport sink   (input valid, sample_count, mean_q8, variance_q16, no_data,
                  count_saturated, output ready);
endinterface

FILE: hw/rtl/running_variance_accumulator_unit.sv
// running population-variance accumulator, top level
// depends on rva_pkg, rva_in_if, rva_out_if, rva_ctrl, rva_dp, rva_div
//
// usage
//   in_req carries one sample per request with a missing flag and a
//   group-start flag; a group start clears count, sum, sum of squares and
//   the saturation flag before the sample is taken
//   out_req returns one result per input request: count, mean (q8),
//   population variance (q16, clamped at zero), no-data and saturation
// sequencing
//   one request at a time; a group with samples runs the mean division and
//   then the mean-of-squares division on the shared radix-2 divider, with
//   SAMPLE_BITS+FRAC_BITS and 2*SAMPLE_BITS-1+2*FRAC_BITS quotient bits;
//   an empty group skips both divisions; in_req.ready returns with
//   out_req.valid
// reset
//   synchronous, active low; accumulators are cleared, both channels idle
// back pressure
//   the result waits in an output register; the next request is accepted
//   and processed meanwhile, and only the final load waits for the receiver
module running_variance_accumulator_unit #(
  parameter int unsigned SAMPLE_BITS = rva_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned COUNT_BITS  = rva_pkg::COUNT_BITS_DEF,
  parameter int unsigned FRAC_BITS   = rva_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  rva_in_if.sink      in_req,
  rva_out_if.source   out_req
);

  // command and status between sequencer and datapath
  rva_pkg::cmd_t cmd;
  rva_pkg::sts_t sts;

  // sequencer: square, accumulate, mean division, mean-of-squares division, load
  rva_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // datapath with accumulators, shared divider and result register
  rva_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_sample           (in_req.sample),
    .in_sample_missing   (in_req.sample_missing),
    .in_group_start      (in_req.group_start),
    .out_valid           (out_req.valid),
    .out_ready           (out_req.ready),
    .out_sample_count    (out_req.sample_count),
    .out_mean_q8         (out_req.mean_q8),
    .out_variance_q16    (out_req.variance_q16),
    .out_no_data         (out_req.no_data),
    .out_count_saturated (out_req.count_saturated)
  );

endmodule

FILE: hw/rtl/rva_div.sv
// shared radix-2 restoring divider, one quotient bit per cycle
// depends on rva_pkg for the default count width; operands come pre-aligned from rva_dp
module rva_div #(
  parameter int unsigned COUNT_BITS = rva_pkg::COUNT_BITS_DEF,
  parameter int unsigned DQ_W       = 78,
  parameter int unsigned STEP_W     = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  ld,
  input  logic [COUNT_BITS-1:0] rem_init,
  input  logic [DQ_W-1:0]       dq_init,
  input  logic [STEP_W-1:0]     steps,
  input  logic [COUNT_BITS-1:0] divisor,
  output logic                  busy,
  output logic                  done,
  output logic [DQ_W-1:0]       quo
);

  logic [COUNT_BITS-1:0] rem_r, rem_nxt;
  logic [DQ_W-1:0]       dq_r;
  logic [STEP_W-1:0]     step_r;
  logic                  busy_r, done_r;
  logic [COUNT_BITS:0]   trial, diff;
  logic                  qbit;

  // shift in the next dividend bit and try the subtraction
  always_comb begin
    trial   = {rem_r, dq_r[DQ_W-1]};
    diff    = trial - {1'b0, divisor};
    qbit    = (trial >= {1'b0, divisor});
    rem_nxt = qbit ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (ld) begin
      rem_r  <= rem_init;
      dq_r   <= dq_init;
      step_r <= steps;
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      dq_r   <= {dq_r[DQ_W-2:0], qbit};
      step_r <= step_r - 1'b1;
      if (step_r == STEP_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = dq_r;

  // partial remainder stays below the divisor while the divider is busy
  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (rem_r < divisor))
    else $error("divider remainder not below divisor");

endmodule

FILE: hw/rtl/rva_dp.sv
// datapath: accumulators, squaring, divider operands, result register
// depends on rva_pkg and instantiates rva_div
module rva_dp #(
  parameter int unsigned SAMPLE_BITS = rva_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned COUNT_BITS  = rva_pkg::COUNT_BITS_DEF,
  parameter int unsigned FRAC_BITS   = rva_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rva_pkg::cmd_t                       cmd,
  output rva_pkg::sts_t                       sts,
  input  logic signed [rva_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                in_sample_missing,
  input  logic                                in_group_start,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [rva_pkg::COUNT_W-1:0]         out_sample_count,
  output logic signed [rva_pkg::MEAN_W-1:0]   out_mean_q8,
  output logic [rva_pkg::VAR_W-1:0]           out_variance_q16,
  output logic                                out_no_data,
  output logic                                out_count_saturated
);

  localparam int unsigned S      = SAMPLE_BITS;
  localparam int unsigned C      = COUNT_BITS;
  localparam int unsigned SUM_W  = C + S;
  localparam int unsigned SQ_W   = C + 2*S - 2;
  localparam int unsigned PSQ_W  = 2*S - 1;
  localparam int unsigned MQ_W   = S + FRAC_BITS;
  localparam int unsigned VQ_W   = 2*S - 1 + 2*FRAC_BITS;
  localparam int unsigned MD_W   = C + S - 1 + FRAC_BITS;
  localparam int unsigned VD_W   = C + 2*S - 2 + 2*FRAC_BITS;
  localparam int unsigned DQ_W   = VD_W;
  localparam int unsigned STEP_W = $clog2(VQ_W + 1);

  logic [S-1:0]            smp_r;
  logic                    miss_r, start_r;
  logic [PSQ_W-1:0]        sq_r;
  logic [C-1:0]            cnt_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [SQ_W-1:0]         sqs_r;
  logic                    sat_r;
  logic                    neg_r;
  logic [MQ_W-1:0]         mean_mag_r;
  logic [VQ_W-1:0]         mmsq_r;

  logic                         out_valid_r, no_data_r, sat_out_r;
  logic [rva_pkg::COUNT_W-1:0]  count_out_r;
  logic [rva_pkg::MEAN_W-1:0]   mean_out_r;
  logic [rva_pkg::VAR_W-1:0]    var_out_r;

  logic [S-1:0]            mag;
  logic [2*S-1:0]          sq_full;
  logic [2*MQ_W-1:0]       mm_full;
  logic [C-1:0]            base_cnt;
  logic signed [SUM_W-1:0] base_sum;
  logic [SQ_W-1:0]         base_sqs;
  logic                    base_sat;
  logic [SUM_W-1:0]        sum_neg;
  logic [SUM_W-2:0]        sum_mag;
  logic [MD_W-1:0]         dvd_m;
  logic [VD_W-1:0]         dvd_v;
  logic [DQ_W-1:0]         dvd_m_ext, dq_init;
  logic [C-1:0]            rem_init;
  logic [STEP_W-1:0]       steps;
  logic                    div_ld, div_busy, div_done;
  logic [DQ_W-1:0]         quo;
  logic [VQ_W-1:0]         msq, var_q;
  logic [rva_pkg::MEAN_W-1:0] mean_ext;

  // magnitude and square of the sample, square of the mean magnitude
  assign mag     = smp_r[S-1] ? (~smp_r + 1'b1) : smp_r;
  assign sq_full = mag * mag;
  assign mm_full = mean_mag_r * mean_mag_r;

  // a group start accumulates onto cleared state
  assign base_cnt = start_r ? '0 : cnt_r;
  assign base_sum = start_r ? '0 : sum_r;
  assign base_sqs = start_r ? '0 : sqs_r;
  assign base_sat = start_r ? 1'b0 : sat_r;

  // divider operands, left aligned so only quotient bits are iterated
  assign sum_neg   = -sum_r;
  assign sum_mag   = sum_r[SUM_W-1] ? sum_neg[SUM_W-2:0] : sum_r[SUM_W-2:0];
  assign dvd_m     = MD_W'(sum_mag) << FRAC_BITS;
  assign dvd_v     = VD_W'(sqs_r) << (2*FRAC_BITS);
  assign dvd_m_ext = DQ_W'(dvd_m);
  assign div_ld    = cmd.mean_ld | cmd.var_ld;

  always_comb begin
    if (cmd.mean_ld) begin
      dq_init  = dvd_m_ext << (DQ_W - MQ_W);
      rem_init = C'(dvd_m_ext >> MQ_W);
      steps    = STEP_W'(MQ_W);
    end else begin
      dq_init  = dvd_v << (DQ_W - VQ_W);
      rem_init = C'(dvd_v >> VQ_W);
      steps    = STEP_W'(VQ_W);
    end
  end

  rva_div #(
    .COUNT_BITS (C),
    .DQ_W       (DQ_W),
    .STEP_W     (STEP_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ld       (div_ld),
    .rem_init (rem_init),
    .dq_init  (dq_init),
    .steps    (steps),
    .divisor  (cnt_r),
    .busy     (div_busy),
    .done     (div_done),
    .quo      (quo)
  );

  // variance from mean of squares minus squared mean, clamped
  assign msq      = quo[VQ_W-1:0];
  assign var_q    = (msq > mmsq_r) ? (msq - mmsq_r) : '0;
  assign mean_ext = rva_pkg::MEAN_W'(mean_mag_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sum_r <= '0;
      sqs_r <= '0;
      sat_r <= 1'b0;
    end else if (cmd.upd) begin
      if (miss_r) begin
        cnt_r <= base_cnt;
        sum_r <= base_sum;
        sqs_r <= base_sqs;
        sat_r <= base_sat;
      end else if (base_cnt == {C{1'b1}}) begin
        cnt_r <= base_cnt;
        sum_r <= base_sum;
        sqs_r <= base_sqs;
        sat_r <= 1'b1;
      end else begin
        cnt_r <= base_cnt + 1'b1;
        sum_r <= base_sum + {{(SUM_W-S){smp_r[S-1]}}, smp_r};
        sqs_r <= base_sqs + SQ_W'(sq_r);
        sat_r <= base_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      smp_r   <= in_sample[S-1:0];
      miss_r  <= in_sample_missing;
      start_r <= in_group_start;
    end
    if (cmd.sq) begin
      sq_r <= sq_full[PSQ_W-1:0];
    end
    if (cmd.mean_ld) begin
      neg_r <= sum_r[SUM_W-1];
    end
    if (cmd.mean_st) begin
      mean_mag_r <= quo[MQ_W-1:0];
    end
    if (cmd.var_ld) begin
      mmsq_r <= mm_full[VQ_W-1:0];
    end
  end

  // result register, frees the input side while the receiver stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      count_out_r <= rva_pkg::COUNT_W'(cnt_r);
      no_data_r   <= (cnt_r == '0);
      sat_out_r   <= sat_r;
      if (cnt_r == '0) begin
        mean_out_r <= '0;
        var_out_r  <= '0;
      end else begin
        mean_out_r <= neg_r ? (~mean_ext + 1'b1) : mean_ext;
        var_out_r  <= rva_pkg::VAR_W'(var_q);
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_sample_count    = count_out_r;
  assign out_mean_q8         = mean_out_r;
  assign out_variance_q16    = var_out_r;
  assign out_no_data         = no_data_r;
  assign out_count_saturated = sat_out_r;

  assign sts.div_busy = div_busy;
  assign sts.div_done = div_done;
  assign sts.cnt_zero = (cnt_r == '0);
  assign sts.out_busy = out_valid_r & ~out_ready;

  // the saturation flag is only ever set with the count pinned at maximum
  a_sat_at_max: assert property (@(posedge clk) disable iff (!rst_n)
    sat_r |-> (cnt_r == {C{1'b1}}))
    else $error("saturation flag set below maximum count");

  // an empty group reports zero mean and variance
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && no_data_r) |-> (mean_out_r == '0 && var_out_r == '0
                                    && count_out_r == '0))
    else $error("empty group result not zero");

endmodule

FILE: hw/rtl/rva_ctrl.sv
// controller: sequences capture, square, accumulate, two divisions unless the group is empty, and result load
// depends on rva_pkg for command and status types
module rva_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output rva_pkg::cmd_t cmd,
  input  rva_pkg::sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQ,
    S_UPD,
    S_MEAN_LD,
    S_MEAN_RUN,
    S_VAR_LD,
    S_VAR_RUN,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_in = 1'b1;
          state_nxt   = S_SQ;
        end
      end
      S_SQ: begin
        cmd.sq    = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_MEAN_LD;
      end
      S_MEAN_LD: begin
        if (sts.cnt_zero) begin
          state_nxt = S_FIN;
        end else begin
          cmd.mean_ld = 1'b1;
          state_nxt   = S_MEAN_RUN;
        end
      end
      S_MEAN_RUN: begin
        if (sts.div_done) begin
          cmd.mean_st = 1'b1;
          state_nxt   = S_VAR_LD;
        end
      end
      S_VAR_LD: begin
        cmd.var_ld = 1'b1;
        state_nxt  = S_VAR_RUN;
      end
      S_VAR_RUN: begin
        if (sts.div_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  // never overwrite a result the receiver has not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !sts.out_busy)
    else $error("result register overwritten");

  // a division is only started on an idle divider
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mean_ld || cmd.var_ld) |-> !sts.div_busy)
    else $error("divider restarted while busy");

  // after a division starts, the divider is busy in the next cycle
  a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mean_ld || cmd.var_ld) |=> sts.div_busy)
    else $error("divider did not start");

endmodule

FILE: tb/tb_running_variance_accumulator_unit.sv
`timescale 1ns / 1ps
// self-checking testbench for the running variance accumulator unit
// depends on rva_pkg, rva_in_if, rva_out_if and the unit's rtl; needs no other file
module tb_running_variance_accumulator_unit;

  // channel field widths
  localparam int unsigned SAMPLE_W     = rva_pkg::SAMPLE_W;
  localparam int unsigned COUNT_W      = rva_pkg::COUNT_W;
  localparam int unsigned MEAN_W       = rva_pkg::MEAN_W;
  localparam int unsigned VAR_W        = rva_pkg::VAR_W;

  // unit parameters at their defaults
  localparam int unsigned SAMPLE_BITS  = rva_pkg::SAMPLE_BITS_DEF;
  localparam int unsigned COUNT_BITS   = rva_pkg::COUNT_BITS_DEF;
  localparam int unsigned FRAC_BITS    = rva_pkg::FRAC_BITS_DEF;
  localparam logic [63:0] COUNT_MAX    = (64'd1 << COUNT_BITS) - 64'd1;
  // result latency of a non-empty group
  localparam int unsigned LATENCY      = 3 * SAMPLE_BITS + 3 * FRAC_BITS + 6;
  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned RAND_ITEMS   = 1250;
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned CYCLE_LIMIT  = 1500000;
  localparam int unsigned DIR_ROWS     = 16;

  // one result request as the unit returns it
  typedef struct packed {
    logic [COUNT_W-1:0]       count;
    logic signed [MEAN_W-1:0] mean;
    logic [VAR_W-1:0]         variance;
    logic                     no_data;
    logic                     saturated;
  } stats_t;

  // directed row: a request repeated reps times, checked against the typed
  // result when fixed is set, else against the running prediction
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                missing;
    logic                start;
    logic [4:0]          reps;
    logic                fixed;
    stats_t              want;
  } dir_row_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_STALL} rx_mode_t;

  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    // nothing accumulated after reset
    '{16'h0000, 1'b1, 1'b0, 5'd1,  1'b1, '{32'd0,  24'h000000, 47'd0, 1'b1, 1'b0}},
    // largest positive sample opens a group
    '{16'h7fff, 1'b0, 1'b1, 5'd1,  1'b1, '{32'd1,  24'h7fff00, 47'd0, 1'b0, 1'b0}},
    // most negative sample next to it, widest spread
    '{16'h8000, 1'b0, 1'b0, 5'd1,  1'b0, '0},
    '{16'h8000, 1'b0, 1'b1, 5'd1,  1'b1, '{32'd1,  24'h800000, 47'd0, 1'b0, 1'b0}},
    '{16'h8000, 1'b0, 1'b0, 5'd1,  1'b1, '{32'd2,  24'h800000, 47'd0, 1'b0, 1'b0}},
    // missing sample leaves the group alone
    '{16'h5a5a, 1'b1, 1'b0, 5'd1,  1'b1, '{32'd2,  24'h800000, 47'd0, 1'b0, 1'b0}},
    // group start with a missing sample gives an empty group
    '{16'h0000, 1'b1, 1'b1, 5'd1,  1'b1, '{32'd0,  24'h000000, 47'd0, 1'b1, 1'b0}},
    '{16'h0000, 1'b0, 1'b0, 5'd1,  1'b1, '{32'd1,  24'h000000, 47'd0, 1'b0, 1'b0}},
    '{16'h0001, 1'b0, 1'b0, 5'd1,  1'b0, '0},
    '{16'hffff, 1'b0, 1'b0, 5'd1,  1'b0, '0},
    // long run of equal extreme samples keeps the variance at zero
    '{16'h7fff, 1'b0, 1'b1, 5'd1,  1'b1, '{32'd1,  24'h7fff00, 47'd0, 1'b0, 1'b0}},
    '{16'h7fff, 1'b0, 1'b0, 5'd13, 1'b0, '0},
    '{16'h7fff, 1'b0, 1'b0, 5'd1,  1'b1, '{32'd15, 24'h7fff00, 47'd0, 1'b0, 1'b0}},
    // far sample after the run, then a missing one
    '{16'h8000, 1'b0, 1'b0, 5'd1,  1'b0, '0},
    '{16'h8000, 1'b1, 1'b0, 5'd1,  1'b0, '0},
    // group start with a missing sample empties the group again
    '{16'h0000, 1'b1, 1'b1, 5'd1,  1'b1, '{32'd0,  24'h000000, 47'd0, 1'b1, 1'b0}}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rva_in_if  in_ch ();
  rva_out_if out_ch ();

  running_variance_accumulator_unit #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_ch),
    .out_req (out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor copy of the group state
  logic [31:0] grp_count = '0;
  longint      grp_sum   = 0;
  logic [63:0] grp_sumsq = '0;
  logic        grp_sat   = 1'b0;

  stats_t due_stats_q[$];
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;

  // sender pacing and the receiver hold-off request
  int unsigned tx_left   = 0;
  bit          tx_steady = 1'b0;
  bit          hold_req  = 1'b0;

  // apply one request to the predicted group and return the stats it yields
  function automatic stats_t predict_group_stats(logic [SAMPLE_W-1:0] raw, logic missing,
                                                 logic start);
    longint      smp;
    logic [63:0] mag, sum_mag, mean_mag, mean_full, quo, rem, msq, msq_mean;
    bit          neg;
    stats_t      res;
    smp = longint'($signed(raw));
    if (start) begin
      grp_count = '0;
      grp_sum   = 0;
      grp_sumsq = '0;
      grp_sat   = 1'b0;
    end
    if (!missing) begin
      if (64'(grp_count) >= COUNT_MAX) begin
        grp_sat = 1'b1;
      end else begin
        mag       = (smp < 0) ? -smp : smp;
        grp_sum   = grp_sum + smp;
        grp_sumsq = grp_sumsq + mag * mag;
        grp_count = grp_count + 1;
      end
    end
    res           = '0;
    res.count     = grp_count;
    res.no_data   = (grp_count == 0);
    res.saturated = grp_sat;
    if (grp_count != 0) begin
      neg       = (grp_sum < 0);
      sum_mag   = neg ? -grp_sum : grp_sum;
      mean_mag  = (sum_mag << FRAC_BITS) / 64'(grp_count);
      // exact mean of squares from quotient and remainder
      quo       = grp_sumsq / 64'(grp_count);
      rem       = grp_sumsq % 64'(grp_count);
      msq       = (quo << (2 * FRAC_BITS)) + ((rem << (2 * FRAC_BITS)) / 64'(grp_count));
      msq_mean  = mean_mag * mean_mag;
      mean_full = neg ? (~mean_mag + 64'd1) : mean_mag;
      res.mean  = mean_full[MEAN_W-1:0];
      // truncation may push the difference below zero, clamp it
      if (msq > msq_mean) begin
        msq          = msq - msq_mean;
        res.variance = msq[VAR_W-1:0];
      end
    end
    return res;
  endfunction

  // draw a sample: fully random, an extreme, or close to the group center
  function automatic logic [SAMPLE_W-1:0] pick_sample(logic [SAMPLE_W-1:0] center);
    logic [SAMPLE_W-1:0] smp;
    case ($urandom_range(0, 9))
      0, 1, 2: smp = SAMPLE_W'($urandom);
      3, 4: begin
        case ($urandom_range(0, 3))
          0:       smp = 16'h7fff;
          1:       smp = 16'h8000;
          2:       smp = 16'h0000;
          default: smp = 16'hffff;
        endcase
      end
      default: smp = center + SAMPLE_W'($urandom_range(0, 64)) - 16'd32;
    endcase
    return smp;
  endfunction

  // offer one request, wait for it to be taken, then idle as the burst says
  task automatic send_item(logic [SAMPLE_W-1:0] smp, logic missing, logic start, bit fixed,
                           stats_t want);
    stats_t      pred;
    int unsigned gap;
    @(negedge clk);
    in_ch.sample         = smp;
    in_ch.sample_missing = missing;
    in_ch.group_start    = start;
    in_ch.valid          = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    pred = predict_group_stats(smp, missing, start);
    due_stats_q.push_back(fixed ? want : pred);
    gap = 0;
    if (tx_left == 0) begin
      tx_left = $urandom_range(1, 12);
      if (!tx_steady) gap = $urandom_range(1, 100);
    end
    tx_left--;
    if (gap != 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // stop offering and let every outstanding result come back
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (due_stats_q.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(string fname, longint want, longint got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
      mismatch_cnt++;
    end
  endtask

  // result side: compare each taken result with the oldest prediction
  always @(posedge clk) begin
    stats_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (due_stats_q.size() == 0) begin
        $display("%0t ns: result with no request outstanding, count %0d", $time,
                 out_ch.sample_count);
        mismatch_cnt++;
      end else begin
        want = due_stats_q.pop_front();
        check_field("sample_count", longint'(want.count), longint'(out_ch.sample_count));
        check_field("mean_q8", longint'(want.mean), longint'(out_ch.mean_q8));
        check_field("variance_q16", longint'(want.variance), longint'(out_ch.variance_q16));
        check_field("no_data", longint'(want.no_data), longint'(out_ch.no_data));
        check_field("count_saturated", longint'(want.saturated),
                    longint'(out_ch.count_saturated));
      end
    end
  end

  // receiver: open, coin-flip and long-stall stretches, plus one long hold-off
  initial begin : receiver
    rx_mode_t    rx_mode;
    int unsigned rx_left;
    int unsigned stall_left;
    rx_mode      = RX_OPEN;
    rx_left      = 0;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        // block fills up behind the held result and stalls its input
        hold_req     = 1'b0;
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        if (rx_left == 0) begin
          rx_mode = rx_mode_t'($urandom_range(0, 2));
          rx_left = $urandom_range(50, 400);
        end
        rx_left--;
        case (rx_mode)
          RX_OPEN: out_ch.ready = 1'b1;
          RX_COIN: out_ch.ready = 1'($urandom_range(0, 1));
          default: begin
            if (stall_left != 0) begin
              out_ch.ready = 1'b0;
              stall_left--;
            end else begin
              out_ch.ready = 1'b1;
              if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 60);
            end
          end
        endcase
      end
    end
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  // watchdog
  initial begin : watchdog
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // sender: reset, directed table, then random groups
  initial begin : stimulus
    dir_row_t            row;
    int unsigned         sent;
    int unsigned         grp_len;
    int unsigned         pos;
    bit                  all_missing;
    logic [SAMPLE_W-1:0] center;
    logic                start;
    logic                missing;
    in_ch.valid          = 1'b0;
    in_ch.sample         = '0;
    in_ch.sample_missing = 1'b0;
    in_ch.group_start    = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int r = 0; r < DIR_ROWS; r++) begin
      row = DIR_TAB[r];
      repeat (row.reps) send_item(row.sample, row.missing, row.start, row.fixed, row.want);
    end
    // sender pause until the directed results are all back
    drain_results();

    sent = 0;
    while (sent < RAND_ITEMS) begin
      // group length: mostly short, some medium, some long
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: grp_len = $urandom_range(1, 8);
        6, 7, 8:          grp_len = $urandom_range(9, 15);
        default:          grp_len = $urandom_range(16, 24);
      endcase
      all_missing = ($urandom_range(0, 19) == 0);
      center      = ($urandom_range(0, 3) == 0) ? SAMPLE_W'($urandom)
                                                : SAMPLE_W'($urandom_range(0, 512)) - 16'd256;
      for (pos = 0; pos < grp_len && sent < RAND_ITEMS; pos++) begin
        // now and then a group runs on without a start or restarts midway
        start   = (pos == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 39) == 0);
        missing = all_missing || ($urandom_range(0, 6) == 0);
        tx_steady = ((sent / 150) % 3) == 1;
        send_item(pick_sample(center), missing, start, 1'b0, '0);
        sent++;
        if (sent == 400) hold_req = 1'b1;
        if (sent == 800) drain_results();
      end
    end

    drain_results();
    repeat (2 * LATENCY) @(posedge clk);
    if (mismatch_cnt == 0 && due_stats_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/rva_pkg.sv
hw/rtl/rva_in_if.sv
hw/rtl/rva_out_if.sv
hw/rtl/rva_div.sv
hw/rtl/rva_dp.sv
hw/rtl/rva_ctrl.sv
hw/rtl/running_variance_accumulator_unit.sv
tb/tb_running_variance_accumulator_unit.sv
